// ===== hdl/mspg_pkg.sv =====
// Shared types, codes and constants for the multi-axis step pulse generator.
package mspg_pkg;

	// Fixed field widths
	localparam int TYPE_W  = 3;
	localparam int AXIS_W  = 4;
	localparam int RATE_W  = 20;
	localparam int POS_W   = 32;
	localparam int CFG_W   = 16;
	localparam int INC_W   = CFG_W + 1;
	localparam int MASK_W  = 3;
	localparam int CFG_IDX_W = 1;

	// Default parameter values
	localparam int AXES_DEF         = 3;
	localparam int TICK_RATE_DEF    = 100000;
	localparam int DEFAULT_RATE_DEF = 1000;

	// Configuration register reset values
	localparam logic [CFG_W-1:0] MIN_RATE_RST = 16'd100;
	localparam logic [CFG_W-1:0] MAX_RATE_RST = 16'd50000;

	// Request codes
	typedef enum logic [TYPE_W-1:0] {
		REQ_TICK     = 3'd0,
		REQ_SET_RATE = 3'd1,
		REQ_START    = 3'd2,
		REQ_STOP     = 3'd3,
		REQ_LOAD_POS = 3'd4
	} req_code_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RATE = 1'd0,
		REG_MAX_RATE = 1'd1
	} cfg_reg_t;

	// Request payload
	typedef struct packed {
		logic [TYPE_W-1:0]       req_type;
		logic [AXIS_W-1:0]       axis;
		logic                    forward;
		logic [RATE_W-1:0]       rate;
		logic signed [POS_W-1:0] new_position;
	} mspg_req_t;

	// Result payload
	typedef struct packed {
		logic [MASK_W-1:0]       step_levels;
		logic [MASK_W-1:0]       dir_levels;
		logic [MASK_W-1:0]       running_mask;
		logic signed [POS_W-1:0] position;
	} mspg_rsp_t;

	// Command broadcast to every axis lane
	typedef struct packed {
		logic              tick;
		logic              hit;
		logic [TYPE_W-1:0] req_type;
		logic              forward;
		logic [INC_W-1:0]  increment;
		logic [POS_W-1:0]  new_position;
	} lane_cmd_t;

	// Axis state after the request
	typedef struct packed {
		logic             step;
		logic             dir;
		logic             run;
		logic [POS_W-1:0] position;
	} lane_stat_t;

endpackage

// ===== hdl/mspg_axis.sv =====
// One axis lane: phase accumulator, step toggle, position counter and command handling.
module mspg_axis
	import mspg_pkg::*;
#(
	parameter int TICK_RATE    = TICK_RATE_DEF,
	parameter int DEFAULT_RATE = DEFAULT_RATE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_cmd_t  cmd,
	output lane_stat_t nxt
);

	localparam int ACC_W = $clog2(TICK_RATE);
	localparam int SUM_W = ((ACC_W > INC_W) ? ACC_W : INC_W) + 1;
	localparam logic [SUM_W-1:0] TICK_S = SUM_W'(TICK_RATE);
	localparam logic [SUM_W-1:0] TOP_S  = SUM_W'(TICK_RATE - 1);

	logic [ACC_W-1:0] acc_q, acc_d;
	logic [INC_W-1:0] inc_q, inc_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             step_q, step_d;
	logic             dir_q, dir_d;
	logic             run_q, run_d;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] rem;

	// Work out the state after this request
	always_comb begin
		acc_d  = acc_q;
		inc_d  = inc_q;
		pos_d  = pos_q;
		step_d = step_q;
		dir_d  = dir_q;
		run_d  = run_q;
		sum    = SUM_W'(acc_q) + SUM_W'(inc_q);
		rem    = sum - TICK_S;
		if (rem > TOP_S) begin
			rem = TOP_S;
		end
		if (cmd.tick && run_q) begin
			if (sum >= TICK_S) begin
				acc_d  = rem[ACC_W-1:0];
				step_d = !step_q;
				// advance position on the falling edge of the step pin
				if (step_q) begin
					pos_d = dir_q ? pos_q + POS_W'(1) : pos_q - POS_W'(1);
				end
			end else begin
				acc_d = sum[ACC_W-1:0];
			end
		end else if (cmd.hit) begin
			case (cmd.req_type)
				REQ_SET_RATE: begin
					inc_d = cmd.increment;
				end
				REQ_START: begin
					dir_d  = cmd.forward;
					step_d = 1'b0;
					acc_d  = '0;
					run_d  = 1'b1;
				end
				REQ_STOP: begin
					run_d  = 1'b0;
					step_d = 1'b0;
				end
				REQ_LOAD_POS: begin
					pos_d = cmd.new_position;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			inc_q  <= INC_W'(DEFAULT_RATE);
			pos_q  <= '0;
			step_q <= 1'b0;
			dir_q  <= 1'b0;
			run_q  <= 1'b0;
		end else begin
			acc_q  <= acc_d;
			inc_q  <= inc_d;
			pos_q  <= pos_d;
			step_q <= step_d;
			dir_q  <= dir_d;
			run_q  <= run_d;
		end
	end

	assign nxt.step     = step_d;
	assign nxt.dir      = dir_d;
	assign nxt.run      = run_d;
	assign nxt.position = pos_d;

endmodule

// ===== hdl/multi_axis_step_pulse_generator.sv =====
// Top level: request register, rate clamp, axis lanes and result register.
// A request is held in the request register, then its result in the result register.
// One request per cycle unless the result register is full and not taken.
// The request register frees whenever the result register is empty or being taken.
// Reset clears all axis state (increment to DEFAULT_RATE), both valid flags
// and the rate limits (floor 100, ceiling 50000).
module multi_axis_step_pulse_generator
	import mspg_pkg::*;
#(
	parameter int AXES         = AXES_DEF,
	parameter int TICK_RATE    = TICK_RATE_DEF,
	parameter int DEFAULT_RATE = DEFAULT_RATE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  mspg_req_t            req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output mspg_rsp_t            rsp_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

	mspg_req_t        req_s1;
	logic             valid_s1;
	mspg_rsp_t        rsp_q;
	logic             rsp_valid_q;
	logic [CFG_W-1:0] min_rate_q;
	logic [CFG_W-1:0] max_rate_q;
	logic             advance;
	logic             axis_ok;
	logic [CFG_W-1:0] clamped;
	lane_cmd_t        cmd;
	lane_stat_t       lane_nxt [AXES];
	mspg_rsp_t        rsp_d;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign axis_ok   = {1'b0, req_s1.axis} < (AXIS_W + 1)'(AXES);

	// Hold the rate limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= MIN_RATE_RST;
			max_rate_q <= MAX_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MIN_RATE: min_rate_q <= cfg_data;
				REG_MAX_RATE: max_rate_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_data;
		end
	end

	// Clamp the requested rate, floor first
	always_comb begin
		if (req_s1.rate < RATE_W'(min_rate_q)) begin
			clamped = min_rate_q;
		end else if (req_s1.rate > RATE_W'(max_rate_q)) begin
			clamped = max_rate_q;
		end else begin
			clamped = req_s1.rate[CFG_W-1:0];
		end
	end

	// Broadcast the command to the lanes
	always_comb begin
		cmd.tick         = advance && (req_s1.req_type == REQ_TICK);
		cmd.hit          = advance && (req_s1.req_type != REQ_TICK) && axis_ok;
		cmd.req_type     = req_s1.req_type;
		cmd.forward      = req_s1.forward;
		cmd.increment    = {clamped, 1'b0};
		cmd.new_position = req_s1.new_position;
	end

	for (genvar i = 0; i < AXES; i++) begin : g_lane
		lane_cmd_t lane_cmd;

		always_comb begin
			lane_cmd     = cmd;
			lane_cmd.hit = cmd.hit && (req_s1.axis == AXIS_W'(i));
		end

		mspg_axis #(
			.TICK_RATE   (TICK_RATE),
			.DEFAULT_RATE(DEFAULT_RATE)
		) u_axis (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (lane_cmd),
			.nxt   (lane_nxt[i])
		);
	end

	// Gather the level masks of the first axes
	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < AXES) begin : g_on
			assign rsp_d.step_levels[i]  = lane_nxt[i].step;
			assign rsp_d.dir_levels[i]   = lane_nxt[i].dir;
			assign rsp_d.running_mask[i] = lane_nxt[i].run;
		end else begin : g_off
			assign rsp_d.step_levels[i]  = 1'b0;
			assign rsp_d.dir_levels[i]   = 1'b0;
			assign rsp_d.running_mask[i] = 1'b0;
		end
	end

	assign rsp_d.position = axis_ok ? lane_nxt[req_s1.axis[IDX_W-1:0]].position : '0;

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Out-of-range axis reads position zero
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !axis_ok |=> rsp_q.position == '0)
		else $error("position not zero for out-of-range axis");

	// Stop on axis zero clears its run and step bits
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.req_type == REQ_STOP && req_s1.axis == '0
		|=> !rsp_q.running_mask[0] && !rsp_q.step_levels[0])
		else $error("stop did not clear axis zero");

	// A step pin is high only on a running axis
	a_step_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.step_levels & ~rsp_q.running_mask) == '0)
		else $error("step level high on stopped axis");

	// Back-pressure only when both registers are full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && rsp_valid_q && !rsp_ready)
		else $error("request stalled with room available");

	// A stalled request stays held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("stalled request lost");

endmodule
